// ===== hdl/iba_pkg.sv =====
// shared constants, types and helpers for the indexed block allocator
package iba_pkg;

    localparam int NUM_BLOCKS      = 128;
    localparam int MAX_FILE_BLOCKS = 32;

    localparam int ADDR_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_FILE_BLOCKS + 1);

    localparam int BLK_FW = 7;
    localparam int POS_FW = 5;
    localparam int LEN_FW = 6;
    localparam int ST_FW  = 3;

    localparam logic CMD_MARK  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic [ST_FW-1:0] ST_GRANTED    = 3'd0;
    localparam logic [ST_FW-1:0] ST_DONE       = 3'd1;
    localparam logic [ST_FW-1:0] ST_INDEX_BUSY = 3'd2;
    localparam logic [ST_FW-1:0] ST_START_BUSY = 3'd3;
    localparam logic [ST_FW-1:0] ST_NO_SPACE   = 3'd4;
    localparam logic [ST_FW-1:0] ST_MARKED     = 3'd5;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic [BLK_FW-1:0] blk;
        logic [POS_FW-1:0] pos;
        logic [ST_FW-1:0]  status;
        logic              last;
    } t_res;

    function automatic logic on_disk(input logic [BLK_FW-1:0] b);
        return (32'(b) < 32'(NUM_BLOCKS));
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [BLK_FW-1:0] b);
        return ADDR_W'(b);
    endfunction

    function automatic logic [BLK_FW-1:0] to_blk(input logic [ADDR_W-1:0] a);
        return BLK_FW'(a);
    endfunction

endpackage

// ===== hdl/iba_bitmap.sv =====
// occupancy bitmap memory, one write port and one registered read port
module iba_bitmap (
    input  logic             i_clk,
    input  iba_pkg::t_mem_req i_req,
    output logic             o_rd_data
);
    import iba_pkg::*;

    logic r_mem [NUM_BLOCKS];
    logic r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/iba_ctrl.sv =====
// command sequencer: clearing pass, index and start checks, circular scan
module iba_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_cmd,
    input  logic [iba_pkg::BLK_FW-1:0] i_index_block,
    input  logic [iba_pkg::BLK_FW-1:0] i_start_block,
    input  logic [iba_pkg::LEN_FW-1:0] i_length,
    input  logic                       i_slot_free,
    input  logic                       i_rd_data,
    output iba_pkg::t_mem_req          o_mem_req,
    output iba_pkg::t_res              o_res
);
    import iba_pkg::*;

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_CHK_IDX   = 3'd2;
    localparam logic [2:0] S_CHK_START = 3'd3;
    localparam logic [2:0] S_SCAN      = 3'd4;
    localparam logic [2:0] S_FINAL     = 3'd5;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BLOCKS - 1);

    logic [2:0]        r_state,    n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [ADDR_W-1:0] r_idx,      n_idx;
    logic [ADDR_W-1:0] r_start,    n_start;
    logic              r_start_ok, n_start_ok;
    logic [CNT_W-1:0]  r_len,      n_len;
    logic [ADDR_W-1:0] r_blk,      n_blk;
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    logic [ST_FW-1:0]  r_status,   n_status;

    logic              free;
    logic [ADDR_W-1:0] blk_nxt;
    logic [CNT_W-1:0]  cnt_nxt;

    assign free    = !i_rd_data;
    assign blk_nxt = (r_blk == LAST_ADDR) ? '0 : r_blk + 1'b1;
    assign cnt_nxt = free ? r_cnt + 1'b1 : r_cnt;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_idx      = r_idx;
        n_start    = r_start;
        n_start_ok = r_start_ok;
        n_len      = r_len;
        n_blk      = r_blk;
        n_cnt      = r_cnt;
        n_status   = r_status;
        o_mem_req  = '0;
        o_mem_req.raddr = r_blk;
        o_res      = '0;

        case (r_state)
            S_CLEAR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_clr_addr;
                o_mem_req.wdata = 1'b0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                o_mem_req.raddr = to_addr(i_index_block);
                if (i_in_valid) begin
                    n_idx      = to_addr(i_index_block);
                    n_start    = to_addr(i_start_block);
                    n_start_ok = on_disk(i_start_block);
                    n_len      = CNT_W'(i_length);
                    n_cnt      = '0;
                    if (i_cmd == CMD_MARK) begin
                        o_mem_req.we    = on_disk(i_index_block);
                        o_mem_req.waddr = to_addr(i_index_block);
                        o_mem_req.wdata = 1'b1;
                        n_status        = ST_MARKED;
                        n_state         = S_FINAL;
                    end else if (i_length == '0 ||
                                 32'(i_length) > 32'(MAX_FILE_BLOCKS)) begin
                        n_status = ST_NO_SPACE;
                        n_state  = S_FINAL;
                    end else if (!on_disk(i_index_block)) begin
                        n_status = ST_INDEX_BUSY;
                        n_state  = S_FINAL;
                    end else begin
                        n_state = S_CHK_IDX;
                    end
                end
            end
            S_CHK_IDX: begin
                if (i_rd_data) begin
                    n_status = ST_INDEX_BUSY;
                    n_state  = S_FINAL;
                end else begin
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = r_idx;
                    o_mem_req.wdata = 1'b1;
                    // start equal to index is busy now that the index is claimed
                    if (!r_start_ok || r_start == r_idx) begin
                        n_status = ST_START_BUSY;
                        n_state  = S_FINAL;
                    end else begin
                        o_mem_req.raddr = r_start;
                        n_state         = S_CHK_START;
                    end
                end
            end
            S_CHK_START: begin
                if (i_rd_data) begin
                    n_status = ST_START_BUSY;
                    n_state  = S_FINAL;
                end else begin
                    // re-read the start so the scan sees it on its first cycle
                    o_mem_req.raddr = r_start;
                    n_blk           = r_start;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (free && !i_slot_free) begin
                    // hold: re-read the same entry until the grant can go out
                    o_mem_req.raddr = r_blk;
                end else begin
                    if (free) begin
                        o_mem_req.we    = 1'b1;
                        o_mem_req.waddr = r_blk;
                        o_mem_req.wdata = 1'b1;
                        o_res.valid     = 1'b1;
                        o_res.blk       = to_blk(r_blk);
                        o_res.pos       = POS_FW'(r_cnt);
                        o_res.status    = ST_GRANTED;
                        o_res.last      = 1'b0;
                    end
                    n_cnt           = cnt_nxt;
                    n_blk           = blk_nxt;
                    o_mem_req.raddr = blk_nxt;
                    if (blk_nxt == r_start || cnt_nxt == r_len) begin
                        n_status = (cnt_nxt == r_len) ? ST_DONE : ST_NO_SPACE;
                        n_state  = S_FINAL;
                    end
                end
            end
            S_FINAL: begin
                if (i_slot_free) begin
                    o_res.valid  = 1'b1;
                    o_res.status = r_status;
                    o_res.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
        r_idx      <= n_idx;
        r_start    <= n_start;
        r_start_ok <= n_start_ok;
        r_len      <= n_len;
        r_blk      <= n_blk;
        r_cnt      <= n_cnt;
        r_status   <= n_status;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/iba_out.sv =====
// output register holding one result word for the downstream handshake
module iba_out (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  iba_pkg::t_res              i_res,
    input  logic                       i_out_ready,
    output logic                       o_slot_free,
    output logic                       o_out_valid,
    output logic [iba_pkg::BLK_FW-1:0] o_out_block,
    output logic [iba_pkg::POS_FW-1:0] o_out_position,
    output logic [iba_pkg::ST_FW-1:0]  o_out_status,
    output logic                       o_out_last
);
    import iba_pkg::*;

    logic              r_valid;
    logic [BLK_FW-1:0] r_blk;
    logic [POS_FW-1:0] r_pos;
    logic [ST_FW-1:0]  r_status;
    logic              r_last;

    assign o_slot_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_slot_free) begin
            r_valid <= i_res.valid;
        end
        if (i_res.valid && o_slot_free) begin
            r_blk    <= i_res.blk;
            r_pos    <= i_res.pos;
            r_status <= i_res.status;
            r_last   <= i_res.last;
        end
    end

    assign o_out_valid    = r_valid;
    assign o_out_block    = r_blk;
    assign o_out_position = r_pos;
    assign o_out_status   = r_status;
    assign o_out_last     = r_last;

endmodule

// ===== hdl/indexed_block_allocator.sv =====
// a mark sets its index entry when on disk and answers with a status word;
// an allocate checks the index, then the start, then scans circularly
// throughput: one command at a time; the scan reads one bitmap entry per
// cycle, except while a found free entry waits for the output slot
// reset: a clearing pass over all NUM_BLOCKS entries runs first; inputs are
// refused until it ends
module indexed_block_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_cmd,
    input  logic [iba_pkg::BLK_FW-1:0] i_index_block,
    input  logic [iba_pkg::BLK_FW-1:0] i_start_block,
    input  logic [iba_pkg::LEN_FW-1:0] i_length,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [iba_pkg::BLK_FW-1:0] o_out_block,
    output logic [iba_pkg::POS_FW-1:0] o_out_position,
    output logic [iba_pkg::ST_FW-1:0]  o_out_status,
    output logic                       o_out_last
);
    import iba_pkg::*;

    t_mem_req mem_req;
    t_res     res;
    logic     rd_data;
    logic     slot_free;

    iba_bitmap u_bitmap (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    iba_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_index_block (i_index_block),
        .i_start_block (i_start_block),
        .i_length      (i_length),
        .i_slot_free   (slot_free),
        .i_rd_data     (rd_data),
        .o_mem_req     (mem_req),
        .o_res         (res)
    );

    iba_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res          (res),
        .i_out_ready    (i_out_ready),
        .o_slot_free    (slot_free),
        .o_out_valid    (o_out_valid),
        .o_out_block    (o_out_block),
        .o_out_position (o_out_position),
        .o_out_status   (o_out_status),
        .o_out_last     (o_out_last)
    );

`ifndef NO_ASSERTIONS
    // a command keeps the block busy in the cycle after it is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after a command");

    // only the closing word of a command carries last
    a_grant_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_status == ST_GRANTED) |-> !o_out_last)
        else $error("grant word flagged as last");

    // status words carry last and zero block and position
    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_status != ST_GRANTED) |->
        (o_out_last && o_out_block == '0 && o_out_position == '0))
        else $error("status word with payload or without last");
`endif

endmodule
